### src/skset_pkg.sv
// ----------------------------------------------------------------------------
// skset_pkg
// Shared types and constants for the sorted key set.
// ----------------------------------------------------------------------------
package skset_pkg;

  localparam int CAPACITY_DEF = 256;
  localparam int KEY_BITS_DEF = 32;

  typedef enum logic [1:0] {
    ACT_ADD      = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_CONTAINS = 2'd2,
    ACT_NOP      = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    RES_ABSENT = 2'd0,
    RES_DONE   = 2'd1,
    RES_FULL   = 2'd2,
    RES_RSVD   = 2'd3
  } res_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SRCH,
    S_INS,
    S_DEL,
    S_DONE
  } state_t;

endpackage

### src/skset_ram.sv
// ----------------------------------------------------------------------------
// skset_ram
// Simple dual-port RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skset_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/sorted_key_set.sv
// Operation: a reserved key or unused action skips the search and goes straight
//   to the result; otherwise a search, then a shift up for an insert or a shift
//   down for a remove.
// Throughput: one item at a time; set by the key memory, with one read and one
//   write port, which is walked one entry per cycle for search and shift.
// Reset: synchronous, active low; the set comes up empty, memory not cleared.
// ----------------------------------------------------------------------------
// sorted_key_set
// Bounded set of distinct signed keys kept sorted in a RAM; add/remove/test.
// ----------------------------------------------------------------------------
module sorted_key_set
  import skset_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int KEY_BITS = KEY_BITS_DEF,
  localparam int CNT_W  = $clog2(CAPACITY + 1),
  localparam int AW     = $clog2(CAPACITY),
  localparam int IN_W   = ((KEY_BITS + 2 + 7) / 8) * 8,
  localparam int OUT_W  = ((CNT_W + 2 + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [IN_W-1:0]  in_tdata,   // [1:0] action, [KEY_BITS+1:2] key
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata   // [1:0] outcome, [CNT_W+1:2] entry_count
);

  localparam logic [KEY_BITS-1:0] SIGN = {1'b1, {(KEY_BITS-1){1'b0}}};

  state_t              state_r, state_nxt;
  act_t                act_r, act_nxt;
  logic [KEY_BITS-1:0] key_r, key_nxt;     // biased: sign flipped
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic [CNT_W-1:0]    pos_r, pos_nxt;
  logic [CNT_W-1:0]    ca_r, ca_nxt;       // address of data in flight
  logic                rv_r, rv_nxt;       // read data valid next cycle
  res_t                res_r, res_nxt;
  logic                ov_r, ov_nxt;
  res_t                out_res_r;
  logic [CNT_W-1:0]    out_cnt_r;
  logic                load_out;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [KEY_BITS-1:0] ram_wdata, ram_rdata;

  logic [KEY_BITS-1:0] in_key_b;
  logic [CNT_W-1:0]    idx_dec;
  logic [CNT_W:0]      idx_inc;
  logic                found, hit;
  logic [CNT_W-1:0]    fpos;

  skset_ram #(
    .WIDTH (KEY_BITS),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_key_b = in_tdata[KEY_BITS+1:2] ^ SIGN;
  assign idx_dec  = idx_r - 1'b1;
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  // first entry not below the key, seen on the returning read
  assign found    = rv_r && (ram_rdata >= key_r);
  assign hit      = found && (ram_rdata == key_r);
  assign fpos     = found ? ca_r : cnt_r;

  always_comb begin
    state_nxt = state_r;
    act_nxt   = act_r;
    key_nxt   = key_r;
    cnt_nxt   = cnt_r;
    idx_nxt   = idx_r;
    pos_nxt   = pos_r;
    ca_nxt    = ca_r;
    rv_nxt    = 1'b0;
    res_nxt   = res_r;
    load_out  = 1'b0;
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = ca_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[AW-1:0];

    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          act_nxt = act_t'(in_tdata[1:0]);
          key_nxt = in_key_b;
          idx_nxt = '0;
          if ((&in_key_b) || act_t'(in_tdata[1:0]) == ACT_NOP) begin
            res_nxt   = RES_ABSENT;
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_SRCH;
          end
        end
      end

      S_SRCH: begin
        if (!found && idx_r < cnt_r) begin
          ram_re  = 1'b1;
          rv_nxt  = 1'b1;
          ca_nxt  = idx_r;
          idx_nxt = idx_r + 1'b1;
        end else begin
          state_nxt = S_DONE;
          res_nxt   = RES_ABSENT;
          case (act_r)
            ACT_ADD: begin
              if (hit) begin
                res_nxt = RES_ABSENT;
              end else if (cnt_r >= CNT_W'(CAPACITY)) begin
                res_nxt = RES_FULL;
              end else begin
                pos_nxt   = fpos;
                idx_nxt   = cnt_r;
                state_nxt = S_INS;
              end
            end
            ACT_REMOVE: begin
              if (hit) begin
                idx_nxt   = fpos;
                state_nxt = S_DEL;
              end
            end
            ACT_CONTAINS: res_nxt = hit ? RES_DONE : RES_ABSENT;
            default:      res_nxt = RES_ABSENT;
          endcase
        end
      end

      // shift entries up from the top down, one per cycle, then drop the key in
      S_INS: begin
        if (rv_r) begin
          ram_we = 1'b1;
        end
        if (idx_r > pos_r) begin
          ram_re    = 1'b1;
          ram_raddr = idx_dec[AW-1:0];
          rv_nxt    = 1'b1;
          ca_nxt    = idx_r;
          idx_nxt   = idx_dec;
        end else if (!rv_r) begin
          ram_we    = 1'b1;
          ram_waddr = pos_r[AW-1:0];
          ram_wdata = key_r;
          cnt_nxt   = cnt_r + 1'b1;
          res_nxt   = RES_DONE;
          state_nxt = S_DONE;
        end
      end

      // shift entries down over the removed one
      S_DEL: begin
        if (rv_r) begin
          ram_we = 1'b1;
        end
        if (idx_inc < {1'b0, cnt_r}) begin
          ram_re    = 1'b1;
          ram_raddr = idx_inc[AW-1:0];
          rv_nxt    = 1'b1;
          ca_nxt    = idx_r;
          idx_nxt   = idx_inc[CNT_W-1:0];
        end else if (!rv_r) begin
          cnt_nxt   = cnt_r - 1'b1;
          res_nxt   = RES_DONE;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (!ov_r || out_tready) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ov_nxt = ov_r;
    if (out_tready) begin
      ov_nxt = 1'b0;
    end
    if (load_out) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      rv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      rv_r    <= rv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    key_r <= key_nxt;
    idx_r <= idx_nxt;
    pos_r <= pos_nxt;
    ca_r  <= ca_nxt;
    res_r <= res_nxt;
    if (load_out) begin
      out_res_r <= res_r;
      out_cnt_r <= cnt_r;
    end
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = OUT_W'({out_cnt_r, out_res_r});

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for sorted_key_set. A short directed table covers empty,
// extreme, reserved and unused-action cases, then random traffic fills,
// drains and churns the set. Each result is checked against its typed table row or
// a sorted queue-based model, with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb;
  import skset_pkg::*;

  localparam int CAP       = CAPACITY_DEF;
  localparam int KEY_W     = KEY_BITS_DEF;
  localparam int CNT_W     = $clog2(CAP + 1);
  localparam int IN_W      = ((KEY_W + 2 + 7) / 8) * 8;
  localparam int OUT_W     = ((CNT_W + 2 + 7) / 8) * 8;
  localparam int N_ITEMS   = 1650;
  localparam int DRAIN_CYC = 2 * CAP + 64;
  localparam int CYC_LIMIT = 4000000;

  typedef logic signed [KEY_W-1:0] key_t;
  typedef logic [CNT_W-1:0]        cnt_t;

  localparam key_t KEY_MIN  = {1'b1, {(KEY_W-1){1'b0}}};
  localparam key_t KEY_RSVD = {1'b0, {(KEY_W-1){1'b1}}};  // never stored
  localparam key_t KEY_TOP  = KEY_RSVD - 1;               // largest usable key

  typedef struct packed {
    res_t outcome;
    cnt_t entry_count;
  } set_result_t;

  typedef struct {
    act_t act;
    key_t key;
    bit   typed;
    res_t outcome;
    cnt_t entry_count;
  } dir_row_t;

  logic             clk = 1'b0;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;   // [1:0] action, [KEY_W+1:2] key
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;  // [1:0] outcome, [CNT_W+1:2] entry_count

  key_t        set_keys[$];         // model of the set, ascending
  set_result_t pending_results[$];  // oldest first
  set_result_t oldest;
  int          fail_cnt;
  int          burst_left;
  int          sent_items;
  int          cycle_cnt;
  int          stall_mode;
  int          stall_left;

  dir_row_t dir_tbl [24] = '{
    '{ACT_CONTAINS, 32'sd0,         1'b1, RES_ABSENT, 9'd0},
    '{ACT_REMOVE,   32'sd5,         1'b1, RES_ABSENT, 9'd0},
    '{ACT_ADD,      KEY_MIN,        1'b1, RES_DONE,   9'd1},
    '{ACT_ADD,      KEY_MIN,        1'b1, RES_ABSENT, 9'd1},
    '{ACT_ADD,      KEY_RSVD,       1'b1, RES_ABSENT, 9'd1},
    '{ACT_CONTAINS, KEY_RSVD,       1'b1, RES_ABSENT, 9'd1},
    '{ACT_REMOVE,   KEY_RSVD,       1'b1, RES_ABSENT, 9'd1},
    '{ACT_ADD,      KEY_TOP,        1'b1, RES_DONE,   9'd2},
    '{ACT_ADD,      32'sd0,         1'b1, RES_DONE,   9'd3},
    '{ACT_ADD,      -32'sd1,        1'b1, RES_DONE,   9'd4},
    '{ACT_CONTAINS, -32'sd1,        1'b1, RES_DONE,   9'd4},
    '{ACT_CONTAINS, KEY_MIN,        1'b1, RES_DONE,   9'd4},
    '{ACT_NOP,      32'sd0,         1'b1, RES_ABSENT, 9'd4},
    '{ACT_NOP,      -32'sd1,        1'b1, RES_ABSENT, 9'd4},
    '{ACT_NOP,      KEY_RSVD,       1'b1, RES_ABSENT, 9'd4},
    '{ACT_REMOVE,   32'sd0,         1'b1, RES_DONE,   9'd3},
    '{ACT_CONTAINS, 32'sd0,         1'b1, RES_ABSENT, 9'd3},
    '{ACT_ADD,      32'sh55555555,  1'b0, RES_ABSENT, 9'd0},
    '{ACT_ADD,      32'shAAAAAAAA,  1'b0, RES_ABSENT, 9'd0},
    '{ACT_CONTAINS, 32'sh55555555,  1'b0, RES_ABSENT, 9'd0},
    '{ACT_REMOVE,   KEY_MIN,        1'b1, RES_DONE,   9'd4},
    '{ACT_REMOVE,   KEY_TOP,        1'b1, RES_DONE,   9'd3},
    '{ACT_REMOVE,   -32'sd1,        1'b1, RES_DONE,   9'd2},
    '{ACT_CONTAINS, KEY_TOP,        1'b1, RES_ABSENT, 9'd2}
  };

  sorted_key_set #(
    .CAPACITY (CAP),
    .KEY_BITS (KEY_W)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one operation to the model set and returns its result.
  function automatic set_result_t apply_set_op(act_t act, key_t key);
    set_result_t r;
    int          pos;
    bit          hit;
    r.outcome = RES_ABSENT;
    pos = 0;
    while (pos < set_keys.size() && set_keys[pos] < key) pos++;
    hit = (pos < set_keys.size()) && (set_keys[pos] == key);
    if (key != KEY_RSVD) begin
      case (act)
        ACT_ADD: begin
          if (hit) begin
            r.outcome = RES_ABSENT;
          end else if (set_keys.size() >= CAP) begin
            r.outcome = RES_FULL;
          end else begin
            set_keys.insert(pos, key);
            r.outcome = RES_DONE;
          end
        end
        ACT_REMOVE: begin
          if (hit) begin
            set_keys.delete(pos);
            r.outcome = RES_DONE;
          end
        end
        ACT_CONTAINS: begin
          if (hit) r.outcome = RES_DONE;
        end
        default: ;
      endcase
    end
    r.entry_count = cnt_t'(set_keys.size());
    return r;
  endfunction

  function automatic key_t pick_held();
    return set_keys[$urandom_range(0, set_keys.size() - 1)];
  endfunction

  function automatic key_t pick_key();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45 && set_keys.size() > 0) return pick_held();
    if (r < 50 && set_keys.size() > 0) return pick_held() + 1;
    if (r < 75) return key_t'($urandom_range(0, 16)) - 8;
    if (r < 93) return key_t'($urandom);
    case ($urandom_range(0, 4))
      0: return KEY_MIN;
      1: return KEY_TOP;
      2: return KEY_RSVD;
      3: return -1;
      default: return '0;
    endcase
  endfunction

  function automatic act_t pick_act();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return ACT_ADD;
    if (r < 65) return ACT_REMOVE;
    if (r < 95) return ACT_CONTAINS;
    return ACT_NOP;
  endfunction

  // Drives one item, waits for acceptance and queues its expected result.
  // Valid stays high after acceptance; it is dropped only before a gap.
  task automatic send_item(input act_t act, input key_t key, input bit typed = 1'b0,
                           input res_t exp_outcome = RES_ABSENT,
                           input cnt_t exp_count = '0);
    set_result_t predicted;
    int          gap;
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      gap = $urandom_range(1, 12);
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 16);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_W-KEY_W-2){1'b0}}, key, act};
    do @(posedge clk); while (!in_tready);
    burst_left--;
    predicted = apply_set_op(act, key);
    if (typed) begin
      predicted.outcome     = exp_outcome;
      predicted.entry_count = exp_count;
    end
    pending_results.push_back(predicted);
    sent_items++;
  endtask

  // Output side: runs of always-ready, random and sparse ready.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_left <= $urandom_range(20, 400);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      default: out_tready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $error("result with nothing pending: outcome %0d, entry_count %0d",
               out_tdata[1:0], out_tdata[CNT_W+1:2]);
        fail_cnt++;
      end else begin
        oldest = pending_results.pop_front();
        if (out_tdata[1:0] !== oldest.outcome) begin
          $error("outcome mismatch: expected %0d, got %0d",
                 oldest.outcome, out_tdata[1:0]);
          fail_cnt++;
        end
        if (out_tdata[CNT_W+1:2] !== oldest.entry_count) begin
          $error("entry_count mismatch: expected %0d, got %0d",
                 oldest.entry_count, out_tdata[CNT_W+1:2]);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYC_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  initial begin
    int n;
    int sel;
    int phase;
    int guard;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_tbl[i])
      send_item(dir_tbl[i].act, dir_tbl[i].key, dir_tbl[i].typed,
                dir_tbl[i].outcome, dir_tbl[i].entry_count);

    phase = 0;
    while (sent_items < N_ITEMS) begin
      sel = (phase == 0) ? 7 : $urandom_range(0, 9);
      phase++;
      if (sel < 6) begin
        n = $urandom_range(20, 80);
        repeat (n) send_item(pick_act(), pick_key());
      end else if (sel < 8) begin
        // fill up, then push on the full store
        guard = 0;
        while (set_keys.size() < CAP && guard < 2 * CAP) begin
          send_item(ACT_ADD, ($urandom_range(0, 9) == 0) ? pick_key() : key_t'($urandom));
          guard++;
        end
        repeat (4) send_item(ACT_ADD, key_t'($urandom));
        repeat (3) send_item(ACT_ADD, pick_held());
        send_item(ACT_ADD, KEY_RSVD);
        repeat (4) send_item(ACT_CONTAINS, pick_key());
        send_item(ACT_REMOVE, pick_held());
        send_item(ACT_ADD, key_t'($urandom));
      end else begin
        while (set_keys.size() > 0) begin
          if ($urandom_range(0, 4) == 0) send_item(pick_act(), pick_key());
          else send_item(ACT_REMOVE, pick_held());
        end
      end
    end
    in_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

### filelist.f
src/skset_pkg.sv
src/skset_ram.sv
src/sorted_key_set.sv
tb/tb.sv
